// File: rtl/core/ir_pulse_distance_decoder_macros.svh
// Assertion macros shared by the infrared pulse-distance decoder RTL.
`ifndef IR_PULSE_DISTANCE_DECODER_MACROS_SVH
`define IR_PULSE_DISTANCE_DECODER_MACROS_SVH

// Check cons in the same cycle as ante.
`define IRPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define IRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/irpd_pkg.sv
// Shared types and constants of the infrared pulse-distance decoder.
`default_nettype none
package irpd_pkg;

    localparam int TIME_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int NUM_BYTES  = 4;
    localparam int BIT_IDX_W  = 3;
    localparam int BYTE_IDX_W = 2;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [TIME_W-1:0] START_LOW_RST     = 16'd500;
    localparam logic [TIME_W-1:0] START_HIGH_RST    = 16'd700;
    localparam logic [TIME_W-1:0] BIT_MAX_RST       = 16'd350;
    localparam logic [TIME_W-1:0] BIT_THRESHOLD_RST = 16'd200;

    localparam logic [BIT_IDX_W-1:0]  LAST_BIT  = 3'd7;
    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = 2'd3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_START_LOW     = 2'd0,
        REG_START_HIGH    = 2'd1,
        REG_BIT_MAX       = 2'd2,
        REG_BIT_THRESHOLD = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [TIME_W-1:0] start_low;
        logic [TIME_W-1:0] start_high;
        logic [TIME_W-1:0] bit_max;
        logic [TIME_W-1:0] bit_threshold;
    } t_cfg;

endpackage
`default_nettype wire

// File: rtl/core/irpd_frame.sv
// Period measurement, pulse classification and frame assembly.
`default_nettype none
`include "ir_pulse_distance_decoder_macros.svh"
module irpd_frame
    import irpd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [TIME_W-1:0] i_time,
    input  wire t_cfg              i_cfg,
    output logic                   o_emit,
    output logic [BYTE_W-1:0]      o_device_address,
    output logic [BYTE_W-1:0]      o_command
);

    logic [TIME_W-1:0]     r_prev_time;
    logic [BIT_IDX_W-1:0]  r_bit_idx;
    logic [BYTE_IDX_W-1:0] r_byte_idx;
    logic [BYTE_W-1:0]     r_frame [NUM_BYTES];

    logic [BIT_IDX_W-1:0]  n_bit_idx;
    logic [BYTE_IDX_W-1:0] n_byte_idx;
    logic [BYTE_W-1:0]     n_frame [NUM_BYTES];

    logic [TIME_W-1:0] period;
    logic              is_start;
    logic              is_bit;
    logic              is_one;

    // Non-increasing timestamps take the wrap path, one short of modular.
    always_comb begin
        if (i_time > r_prev_time) begin
            period = i_time - r_prev_time;
        end else begin
            period = (~r_prev_time) + i_time;
        end
    end

    assign is_start = (period > i_cfg.start_low) && (period < i_cfg.start_high);
    assign is_bit   = !is_start && (period < i_cfg.bit_max);
    assign is_one   = period > i_cfg.bit_threshold;
    assign o_emit   = is_bit && (r_bit_idx == LAST_BIT) && (r_byte_idx == LAST_BYTE);

    always_comb begin
        n_bit_idx  = r_bit_idx;
        n_byte_idx = r_byte_idx;
        for (int i = 0; i < NUM_BYTES; i++) begin
            n_frame[i] = r_frame[i];
        end
        if (is_start) begin
            n_bit_idx  = '0;
            n_byte_idx = '0;
            for (int i = 0; i < NUM_BYTES; i++) begin
                n_frame[i] = '0;
            end
        end else if (is_bit) begin
            if (is_one) begin
                n_frame[r_byte_idx][r_bit_idx] = 1'b1;
            end
            // Byte index wraps to zero after the last byte, which ends the frame.
            n_bit_idx = r_bit_idx + 1'b1;
            if (r_bit_idx == LAST_BIT) begin
                n_byte_idx = r_byte_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_bit_idx   <= '0;
            r_byte_idx  <= '0;
            for (int i = 0; i < NUM_BYTES; i++) begin
                r_frame[i] <= '0;
            end
        end else if (i_step) begin
            r_prev_time <= i_time;
            r_bit_idx   <= n_bit_idx;
            r_byte_idx  <= n_byte_idx;
            for (int i = 0; i < NUM_BYTES; i++) begin
                r_frame[i] <= n_frame[i];
            end
        end
    end

    // The last data bit lands in byte 3, so bytes 0 and 2 are final already.
    assign o_device_address = r_frame[0];
    assign o_command        = r_frame[2];

    `IRPD_ASSERT_NEXT(a_emit_clears_cnt, i_clk, i_rst_n, i_step && o_emit,
        (r_bit_idx == '0) && (r_byte_idx == '0), "counters not cleared after frame")
    `IRPD_ASSERT_NEXT(a_start_clears_frame, i_clk, i_rst_n, i_step && is_start,
        (r_frame[0] == '0) && (r_frame[1] == '0) && (r_frame[2] == '0) && (r_frame[3] == '0),
        "frame not cleared by start pulse")
    `IRPD_ASSERT_NEXT(a_ignored_holds, i_clk, i_rst_n, i_step && !is_start && !is_bit,
        $stable(r_bit_idx) && $stable(r_byte_idx) && $stable(r_frame[r_byte_idx]),
        "ignored period changed frame state")
    `IRPD_ASSERT_NEXT(a_prev_time_tracks, i_clk, i_rst_n, i_step,
        r_prev_time == $past(i_time), "previous timestamp not updated")

endmodule
`default_nettype wire

// File: rtl/core/ir_pulse_distance_decoder.sv
// Top level of the infrared pulse-distance (four-byte frame) remote decoder.
// Each input beat is one 16-bit capture timestamp taken at an edge of the
// demodulated remote signal. The block measures the period since the previous
// edge; a period inside the start window (start_low, start_high) clears the
// frame, any other period below bit_max is one data bit (LSB first, one when
// above bit_threshold), anything else is ignored. After 32 data bits one
// output beat carries byte 0 as device address and byte 2 as command. Rate:
// one input beat per clock unless a completed frame waits on a stalled
// output. An accepted timestamp is held in the input register, classified
// and folded into the frame by a single subtract-and-compare pass, and a
// completed frame is then loaded into the output register.
// The output register holds a finished result under stall while later beats
// that do not complete a frame keep flowing; only a beat that would complete
// a second frame waits for the output register to free.
// Thresholds sit in four 16-bit APB registers at byte addresses 0, 4, 8, 12;
// write them only while the decoder is idle.
`default_nettype none
module ir_pulse_distance_decoder
    import irpd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Timestamp input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [TIME_W-1:0]     i_capture_time,

    // Decoded frame output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [BYTE_W-1:0]          o_device_address,
    output logic [BYTE_W-1:0]          o_command,

    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    t_cfg                r_cfg;
    t_reg_idx            reg_idx;
    logic                cfg_wr;

    logic                r_in_valid;
    logic [TIME_W-1:0]   r_in_time;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_addr;
    logic [BYTE_W-1:0]   r_out_key;

    logic                in_accept;
    logic                proc_fire;
    logic                emit;
    logic [BYTE_W-1:0]   frame_addr;
    logic [BYTE_W-1:0]   frame_key;

    // ---------------------------------------------------------------------
    // Configuration registers: word index from paddr[3:2], zero wait states.
    // ---------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low     <= START_LOW_RST;
            r_cfg.start_high    <= START_HIGH_RST;
            r_cfg.bit_max       <= BIT_MAX_RST;
            r_cfg.bit_threshold <= BIT_THRESHOLD_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_START_LOW:     r_cfg.start_low     <= pwdata[TIME_W-1:0];
                REG_START_HIGH:    r_cfg.start_high    <= pwdata[TIME_W-1:0];
                REG_BIT_MAX:       r_cfg.bit_max       <= pwdata[TIME_W-1:0];
                REG_BIT_THRESHOLD: r_cfg.bit_threshold <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_START_LOW:     prdata = APB_DATA_W'(r_cfg.start_low);
            REG_START_HIGH:    prdata = APB_DATA_W'(r_cfg.start_high);
            REG_BIT_MAX:       prdata = APB_DATA_W'(r_cfg.bit_max);
            REG_BIT_THRESHOLD: prdata = APB_DATA_W'(r_cfg.bit_threshold);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Input register. Advance the held timestamp unless it completes a frame
    // while the output register is still full and stalled.
    // ---------------------------------------------------------------------
    assign proc_fire  = r_in_valid && (!emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proc_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_time <= i_capture_time;
        end
    end

    // ---------------------------------------------------------------------
    // Period classification and frame state.
    // ---------------------------------------------------------------------
    irpd_frame u_frame (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (proc_fire),
        .i_time           (r_in_time),
        .i_cfg            (r_cfg),
        .o_emit           (emit),
        .o_device_address (frame_addr),
        .o_command        (frame_key)
    );

    // ---------------------------------------------------------------------
    // Output register: load on a completed frame, drop once the beat is taken.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && emit) begin
            r_out_addr <= frame_addr;
            r_out_key  <= frame_key;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_device_address = r_out_addr;
    assign o_command        = r_out_key;

endmodule
`default_nettype wire

// File: test/ir_pulse_distance_decoder_tb.sv
// Self-checking testbench for the infrared pulse-distance frame decoder.
`timescale 1ns / 100ps

module ir_pulse_distance_decoder_tb;
    import irpd_pkg::*;

    localparam int QUIET_LIMIT  = 5000;  // cycles without any beat before giving up
    localparam int DRAIN_CYCLES = 4;     // margin past the input and output registers
    localparam int HOLDOFF_LEN  = 400;   // long receiver stall that backs up the input

    // How the previous-edge period is classified by the decoder.
    typedef enum logic [1:0] {
        PERIOD_START,
        PERIOD_ZERO,
        PERIOD_ONE,
        PERIOD_IGNORED
    } t_period_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] device_address;
        logic [BYTE_W-1:0] command;
    } t_decoded_frame;

    // Frame predictor plus the store of frames still owed by the decoder.
    class ir_frame_scoreboard;
        t_cfg              thresholds;
        logic [TIME_W-1:0] last_edge;
        logic [3:0]        bit_pos;
        logic [2:0]        byte_pos;
        logic [BYTE_W-1:0] frame_buf [NUM_BYTES];
        t_decoded_frame    expected_frames [$];
        int                errors;

        function new();
            thresholds.start_low     = START_LOW_RST;
            thresholds.start_high    = START_HIGH_RST;
            thresholds.bit_max       = BIT_MAX_RST;
            thresholds.bit_threshold = BIT_THRESHOLD_RST;
            last_edge = '0;
            bit_pos   = '0;
            byte_pos  = '0;
            foreach (frame_buf[i]) frame_buf[i] = '0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [TIME_W-1:0] value);
            case (idx)
                REG_START_LOW:     thresholds.start_low     = value;
                REG_START_HIGH:    thresholds.start_high    = value;
                REG_BIT_MAX:       thresholds.bit_max       = value;
                REG_BIT_THRESHOLD: thresholds.bit_threshold = value;
                default: ;
            endcase
        endfunction

        // Wrapped periods come out one short of the true modular difference.
        function logic [TIME_W-1:0] period_between(logic [TIME_W-1:0] prev,
                                                   logic [TIME_W-1:0] now);
            if (now > prev) return now - prev;
            return (16'hFFFF - prev) + now;
        endfunction

        // Start window wins over the bit window when they overlap.
        function t_period_kind kind_of(logic [TIME_W-1:0] p);
            if (p > thresholds.start_low && p < thresholds.start_high) return PERIOD_START;
            if (p >= thresholds.bit_max) return PERIOD_IGNORED;
            if (p > thresholds.bit_threshold) return PERIOD_ONE;
            return PERIOD_ZERO;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // Fold one accepted timestamp into the frame, queue a frame when 32 bits are in.
        function void note_capture(logic [TIME_W-1:0] now);
            t_period_kind   kind;
            t_decoded_frame frame;
            kind = kind_of(period_between(last_edge, now));
            last_edge = now;
            case (kind)
                PERIOD_START: begin
                    bit_pos  = '0;
                    byte_pos = '0;
                    foreach (frame_buf[i]) frame_buf[i] = '0;
                end
                PERIOD_ZERO, PERIOD_ONE: begin
                    if (kind == PERIOD_ONE) frame_buf[byte_pos[1:0]][bit_pos[2:0]] = 1'b1;
                    bit_pos = bit_pos + 4'd1;
                    if (bit_pos >= 4'd8) begin
                        bit_pos  = '0;
                        byte_pos = byte_pos + 3'd1;
                    end
                    if (byte_pos > 3'd3) begin
                        frame.device_address = frame_buf[0];
                        frame.command        = frame_buf[2];
                        expected_frames.push_back(frame);
                        bit_pos  = '0;
                        byte_pos = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_frame(logic [BYTE_W-1:0] addr, logic [BYTE_W-1:0] cmd);
            t_decoded_frame frame;
            if (expected_frames.size() == 0) begin
                $display("%0t: frame with none expected: address %h command %h",
                         $time, addr, cmd);
                errors++;
                return;
            end
            frame = expected_frames.pop_front();
            if (addr !== frame.device_address) begin
                $display("%0t: device_address mismatch: expected %h actual %h",
                         $time, frame.device_address, addr);
                errors++;
            end
            if (cmd !== frame.command) begin
                $display("%0t: command mismatch: expected %h actual %h",
                         $time, frame.command, cmd);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  ts_valid;
    logic                  o_in_stall;
    logic [TIME_W-1:0]     ts_time;
    logic                  o_out_valid;
    logic                  frame_stall;
    logic [BYTE_W-1:0]     o_device_address;
    logic [BYTE_W-1:0]     o_command;
    logic                  apb_sel;
    logic                  apb_enable;
    logic                  apb_write;
    logic [APB_ADDR_W-1:0] apb_addr;
    logic [APB_DATA_W-1:0] apb_wdata;
    logic [APB_DATA_W-1:0] apb_rdata;
    logic                  apb_ready;

    ir_frame_scoreboard sb;
    logic [TIME_W-1:0]  last_sent;       // last timestamp handed to the decoder
    int                 items_sent;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 holdoff_cycles;

    ir_pulse_distance_decoder i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (ts_valid),
        .o_in_stall       (o_in_stall),
        .i_capture_time   (ts_time),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (frame_stall),
        .o_device_address (o_device_address),
        .o_command        (o_command),
        .psel             (apb_sel),
        .penable          (apb_enable),
        .pwrite           (apb_write),
        .paddr            (apb_addr),
        .pwdata           (apb_wdata),
        .prdata           (apb_rdata),
        .pready           (apb_ready)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sample both channels at the rising edge; check results before noting the
    // new timestamp, though a timestamp never completes a frame in its own cycle.
    always @(posedge clk) begin
        if (rst_n) begin
            if (o_out_valid && !frame_stall) sb.check_frame(o_device_address, o_command);
            if (ts_valid && !o_in_stall) sb.note_capture(ts_time);
        end
    end

    // Receiver: random stall per phase, or one long hold-off when requested.
    initial begin
        frame_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (holdoff_cycles > 0) begin
                frame_stall <= 1'b1;
                repeat (holdoff_cycles) @(negedge clk);
                holdoff_cycles = 0;
            end
            frame_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: drop out if nothing moves for too long.
    initial begin : watchdog
        int quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((ts_valid && !o_in_stall) || (o_out_valid && !frame_stall) ||
                (apb_sel && apb_enable))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one timestamp beat, idle first as the phase asks, and hold it until
    // accepted. Called and returns at a falling edge.
    task automatic send_capture(input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            ts_valid <= 1'b0;
            @(negedge clk);
        end
        ts_valid <= 1'b1;
        ts_time  <= t;
        last_sent = t;
        items_sent++;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Search for a timestamp whose period from the last one lands in the wanted class.
    function automatic bit find_capture(input t_period_kind want,
                                        output logic [TIME_W-1:0] t);
        int                lo, hi, p;
        logic [TIME_W-1:0] cand;
        t = '0;
        case (want)
            PERIOD_START: begin
                lo = int'(sb.thresholds.start_low) + 1;
                hi = int'(sb.thresholds.start_high) - 1;
            end
            PERIOD_ZERO: begin
                lo = 0;
                hi = int'(sb.thresholds.bit_threshold);
                if (hi > int'(sb.thresholds.bit_max) - 1) hi = int'(sb.thresholds.bit_max) - 1;
            end
            default: begin
                lo = int'(sb.thresholds.bit_threshold) + 1;
                hi = int'(sb.thresholds.bit_max) - 1;
            end
        endcase
        if (lo > hi) return 1'b0;
        for (int k = 0; k < 32; k++) begin
            p = $urandom_range(hi, lo);
            // Step past the wrap by one extra count to undo the short wrapped period.
            if (p > 0 && int'(last_sent) + p <= 65535) cand = 16'(int'(last_sent) + p);
            else cand = 16'(int'(last_sent) + p + 1);
            if (sb.kind_of(sb.period_between(last_sent, cand)) == want) begin
                t = cand;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // One frame with random content; sometimes without a start, cut short or with noise.
    task automatic send_frame();
        logic [TIME_W-1:0] t;
        int                n_bits;
        bit                want_one;
        if ($urandom_range(9) != 0 && find_capture(PERIOD_START, t)) send_capture(t);
        n_bits = ($urandom_range(9) == 0) ? $urandom_range(31, 1) : 32;
        for (int i = 0; i < n_bits; i++) begin
            if ($urandom_range(49) == 0) send_capture(16'($urandom));
            want_one = 1'($urandom_range(1));
            if (find_capture(want_one ? PERIOD_ONE : PERIOD_ZERO, t)) send_capture(t);
            else if (find_capture(want_one ? PERIOD_ZERO : PERIOD_ONE, t)) send_capture(t);
            else send_capture(16'($urandom));
        end
    endtask

    // A few stray edges: random, repeated, and the timer extremes.
    task automatic send_noise();
        int n;
        n = $urandom_range(4, 1);
        repeat (n) begin
            case ($urandom_range(3))
                0: send_capture(16'($urandom));
                1: send_capture(last_sent);
                2: send_capture(16'h0000);
                default: send_capture(16'hFFFF);
            endcase
        end
    endtask

    // APB access helpers: setup cycle, access cycle, then idle.
    task automatic read_reg(input t_reg_idx idx, output logic [APB_DATA_W-1:0] value);
        apb_sel    <= 1'b1;
        apb_enable <= 1'b0;
        apb_write  <= 1'b0;
        apb_addr   <= {idx, 2'b00};
        @(negedge clk);
        apb_enable <= 1'b1;
        @(posedge clk);
        while (!apb_ready) @(posedge clk);
        value = apb_rdata;
        @(negedge clk);
        apb_sel    <= 1'b0;
        apb_enable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_reg(input t_reg_idx idx, input logic [TIME_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        apb_sel    <= 1'b1;
        apb_enable <= 1'b0;
        apb_write  <= 1'b1;
        apb_addr   <= {idx, 2'b00};
        apb_wdata  <= APB_DATA_W'(value);
        @(negedge clk);
        apb_enable <= 1'b1;
        @(posedge clk);
        while (!apb_ready) @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
        apb_sel    <= 1'b0;
        apb_enable <= 1'b0;
        @(negedge clk);
        read_reg(idx, readback);
        if (readback[TIME_W-1:0] !== value) begin
            $display("%0t: register %s readback mismatch: expected %h actual %h",
                     $time, idx.name(), value, readback[TIME_W-1:0]);
            sb.errors++;
        end
    endtask

    // Hold the input low until every owed frame is out and the pipeline is empty.
    task automatic drain_decoder();
        ts_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic t_cfg random_thresholds();
        t_cfg c;
        int   bmax, thr, slo, shi;
        bmax = $urandom_range(4000, 8);
        thr  = $urandom_range(bmax - 2, 1);
        slo  = $urandom_range(bmax + 3000, bmax);
        shi  = slo + $urandom_range(3000, 2);
        c.start_low     = 16'(slo);
        c.start_high    = 16'(shi);
        c.bit_max       = 16'(bmax);
        c.bit_threshold = 16'(thr);
        return c;
    endfunction

    // Retune the thresholds on an idle decoder, then stream frames and noise.
    task automatic run_phase(input t_cfg c, input int idle_pct, input int stall_pct,
                             input int n_items, input bit pressure);
        int target;
        drain_decoder();
        program_reg(REG_START_LOW,     c.start_low);
        program_reg(REG_START_HIGH,    c.start_high);
        program_reg(REG_BIT_MAX,       c.bit_max);
        program_reg(REG_BIT_THRESHOLD, c.bit_threshold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (pressure) holdoff_cycles = HOLDOFF_LEN;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(99) < 80) send_frame();
            else send_noise();
        end
    endtask

    initial begin
        logic [TIME_W-1:0]     directed [] = '{
            16'd0,      // equal to the reset timestamp: period is the maximum, ignored
            16'd600,    // start pulse
            16'd700,    // zero bit
            16'd1000,   // one bit
            16'd1000,   // equal timestamps again
            16'd1200,   // exactly on the bit threshold: zero
            16'd1401,   // just above the threshold: one
            16'd1750,   // just below bit_max: one
            16'd2100,   // exactly bit_max: ignored
            16'd2600,   // exactly start_low: not a start, ignored
            16'd3300,   // exactly start_high: not a start, ignored
            16'd3801,   // just inside the start window
            16'd4500,   // just inside the top of the start window
            16'd65535,  // long gap, ignored
            16'd100,    // wrapped timestamp: period comes out short
            16'd65535,
            16'd0,      // wrap from the top count gives a zero period
            16'd150
        };
        logic [APB_DATA_W-1:0] readback;
        t_cfg                  c;

        sb             = new();
        rst_n          = 1'b0;
        ts_valid       = 1'b0;
        ts_time        = '0;
        apb_sel        = 1'b0;
        apb_enable     = 1'b0;
        apb_write      = 1'b0;
        apb_addr       = '0;
        apb_wdata      = '0;
        last_sent      = '0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_cycles = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values of the threshold registers.
        read_reg(REG_START_LOW, readback);
        if (readback[TIME_W-1:0] !== START_LOW_RST) begin
            $display("%0t: start_low reset mismatch: expected %h actual %h",
                     $time, START_LOW_RST, readback[TIME_W-1:0]);
            sb.errors++;
        end
        read_reg(REG_BIT_THRESHOLD, readback);
        if (readback[TIME_W-1:0] !== BIT_THRESHOLD_RST) begin
            $display("%0t: bit_threshold reset mismatch: expected %h actual %h",
                     $time, BIT_THRESHOLD_RST, readback[TIME_W-1:0]);
            sb.errors++;
        end

        // Window edges, wrap and equal timestamps under the reset thresholds.
        foreach (directed[i]) send_capture(directed[i]);

        c = '{START_LOW_RST, START_HIGH_RST, BIT_MAX_RST, BIT_THRESHOLD_RST};
        run_phase(c, 0, 0, 200, 1'b0);
        run_phase(random_thresholds(), 79, 0, 250, 1'b0);
        run_phase(random_thresholds(), 0, 79, 250, 1'b0);
        // Long receiver hold-off with the sender at full rate backs up the input.
        run_phase(random_thresholds(), 0, 0, 200, 1'b1);
        // Everything at the top: every period but the maximum is a zero bit.
        c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        run_phase(c, 6, 6, 150, 1'b0);
        // Widest start window: only a zero period can be a bit.
        c = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
        run_phase(c, 0, 0, 100, 1'b0);
        // Everything at zero: no window admits any period.
        c = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        run_phase(c, 0, 79, 60, 1'b0);
        // Start window overlapping the bit window.
        c = '{16'd100, 16'd300, 16'd400, 16'd150};
        run_phase(c, 6, 6, 250, 1'b0);
        // Inverted start window, threshold two below bit_max.
        c = '{16'd800, 16'd600, 16'd1000, 16'd998};
        run_phase(c, 79, 0, 200, 1'b0);
        run_phase(random_thresholds(), 0, 0, 200, 1'b0);

        drain_decoder();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/irpd_pkg.sv
rtl/core/irpd_frame.sv
rtl/core/ir_pulse_distance_decoder.sv
test/ir_pulse_distance_decoder_tb.sv
